/* hw/rtl/mm3_pkg.sv */
// shared types and constants for the murmur3 32-bit hash block
// no dependencies; imported by mm3_ctrl and murmur3_hash_32
`timescale 1ns / 1ps
`default_nettype none

package mm3_pkg;

    localparam logic [31:0] MIX_C1     = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2     = 32'h1b873593;
    localparam logic [31:0] ROUND_MUL  = 32'd5;
    localparam logic [31:0] ROUND_ADD  = 32'he6546b64;
    localparam logic [31:0] FIN_M1     = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2     = 32'hc2b2ae35;
    localparam logic [31:0] SEED_RESET = 32'hb6871303;
    localparam logic [31:0] BODY_BYTES = 32'd4;
    localparam logic [2:0]  MAX_BYTES  = 3'd4;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MIX1,
        S_MIX2,
        S_ROUND,
        S_FIN1,
        S_FIN2,
        S_EMIT
    } t_state;

    // operation steered onto the shared multiply-add unit
    typedef enum logic [2:0] {
        OP_NONE,
        OP_MIX1,
        OP_MIX2,
        OP_ROUND,
        OP_FIN1,
        OP_FIN2
    } t_op;

    // status from datapath to sequencer
    typedef struct packed {
        logic in_valid;
        logic in_last;
        logic in_empty;
        logic full_block;
        logic is_last;
        logic out_free;
    } t_stat;

    // controls from sequencer to datapath
    typedef struct packed {
        logic ready;
        t_op  op;
        logic emit;
    } t_ctrl;

endpackage

`default_nettype wire

/* hw/rtl/mm3_mac.sv */
// shared 32-bit multiply-add unit, result kept modulo 2^32
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mm3_mac (
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    input  wire logic [31:0] i_c,
    output logic      [31:0] o_p
);

    logic [31:0] w_prod;

    // low half of the product is all the hash needs
    assign w_prod = i_a * i_b;
    assign o_p    = w_prod + i_c;

endmodule

`default_nettype wire

/* hw/rtl/mm3_ctrl.sv */
// sequencer for the murmur3 block: walks one beat through the shared unit
// depends on mm3_pkg
`timescale 1ns / 1ps
`default_nettype none

module mm3_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mm3_pkg::t_stat i_stat,
    output mm3_pkg::t_ctrl     o_ctrl
);

    import mm3_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_stat.in_valid) begin
                    n_state = (i_stat.in_last && i_stat.in_empty) ? S_FIN1 : S_MIX1;
                end
            end
            S_MIX1:  n_state = S_MIX2;
            S_MIX2:  n_state = i_stat.full_block ? S_ROUND : S_FIN1;
            S_ROUND: n_state = i_stat.is_last ? S_FIN1 : S_IDLE;
            S_FIN1:  n_state = S_FIN2;
            S_FIN2:  n_state = S_EMIT;
            S_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ctrl.ready = 1'b0;
        o_ctrl.op    = OP_NONE;
        o_ctrl.emit  = 1'b0;
        unique case (r_state)
            S_IDLE:  o_ctrl.ready = 1'b1;
            S_MIX1:  o_ctrl.op    = OP_MIX1;
            S_MIX2:  o_ctrl.op    = OP_MIX2;
            S_ROUND: o_ctrl.op    = OP_ROUND;
            S_FIN1:  o_ctrl.op    = OP_FIN1;
            S_FIN2:  o_ctrl.op    = OP_FIN2;
            S_EMIT:  o_ctrl.emit  = i_stat.out_free;
            default: o_ctrl.ready = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/murmur3_hash_32.sv */
// top level of the 32-bit murmur3 hash block: datapath, seed register, output stage
// depends on mm3_pkg, mm3_mac and mm3_ctrl
`timescale 1ns / 1ps
`default_nettype none

// Streams a key in as little-endian 32-bit beats and returns its 32-bit
// MurmurHash3. Beats without tlast are full 4-byte body blocks (tuser is
// ignored on them). The tlast beat carries 0 to 4 bytes, given in tuser
// (values above 4 count as 4); bytes above that count are ignored. The key
// length is xored in, the fmix32 finalizer runs and one hash beat leaves
// on the master side. An accepted body beat makes three passes through
// the single 32x32 multiply-add unit before another beat is taken. A last
// beat of 1 to 3 bytes is first scrambled, one of 4 gets a body round;
// all then wait for the previous hash to be taken. The seed written on the
// configuration port applies from the start of the next key. The finished
// hash waits in an output register, so the next key can start meanwhile.

module murmur3_hash_32 (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // seed register
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    // key beats
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] data_word
    input  wire logic [2:0]  s_axis_tuser,   // [2:0] byte_count
    input  wire logic        s_axis_tlast,   // is_last
    // hash beats
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata    // [31:0] hash_value
);

    import mm3_pkg::*;

    t_stat w_stat;
    t_ctrl w_ctrl;

    // configuration
    logic [31:0] r_seed;

    // per-key and per-beat state
    logic        r_in_key;
    logic [31:0] r_hash;
    logic [31:0] r_len;
    logic [31:0] r_word;
    logic [31:0] r_k;
    logic        r_last;
    logic        r_tail;     // last beat with 1 to 3 bytes

    // output stage
    logic        r_out_valid;
    logic [31:0] r_out_data;

    // incoming beat decode
    logic        w_accept;
    logic [2:0]  w_cnt;
    logic [31:0] w_mask;
    logic [31:0] w_len_base;
    logic [31:0] w_len_add;

    // shared unit operands
    logic [31:0] w_mac_a;
    logic [31:0] w_mac_b;
    logic [31:0] w_mac_c;
    logic [31:0] w_mac_p;
    logic [31:0] w_mix_h;    // hash xored with the scrambled block
    logic [31:0] w_fin_x;    // hash with tail, length and first shift-xor
    logic [31:0] w_fin_y;    // second shift-xor of the finalizer
    logic [31:0] w_fin_pre;

    assign w_accept = s_axis_tvalid && w_ctrl.ready;

    always_comb begin
        // saturate the byte count, full block on non-last beats
        if (!s_axis_tlast || s_axis_tuser > MAX_BYTES) begin
            w_cnt = MAX_BYTES;
        end else begin
            w_cnt = s_axis_tuser;
        end
        w_mask = '0;
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < w_cnt) begin
                w_mask[8*i +: 8] = 8'hff;
            end
        end
        w_len_base = r_in_key ? r_len : '0;
        w_len_add  = s_axis_tlast ? {29'd0, w_cnt} : BODY_BYTES;
    end

    // operand steering for the multiply-add unit
    always_comb begin
        w_mix_h   = r_hash ^ r_k;
        w_fin_pre = r_hash ^ r_len ^ (r_tail ? r_k : '0);
        w_fin_x   = w_fin_pre ^ (w_fin_pre >> 16);
        w_fin_y   = r_hash ^ (r_hash >> 13);
        w_mac_a   = '0;
        w_mac_b   = '0;
        w_mac_c   = '0;
        unique case (w_ctrl.op)
            OP_NONE: begin
                w_mac_a = '0;
            end
            OP_MIX1: begin
                w_mac_a = r_word;
                w_mac_b = MIX_C1;
            end
            OP_MIX2: begin
                // rotl 15 of the first product
                w_mac_a = {r_k[16:0], r_k[31:17]};
                w_mac_b = MIX_C2;
            end
            OP_ROUND: begin
                // rotl 13, then h*5 + add
                w_mac_a = {w_mix_h[18:0], w_mix_h[31:19]};
                w_mac_b = ROUND_MUL;
                w_mac_c = ROUND_ADD;
            end
            OP_FIN1: begin
                w_mac_a = w_fin_x;
                w_mac_b = FIN_M1;
            end
            OP_FIN2: begin
                w_mac_a = w_fin_y;
                w_mac_b = FIN_M2;
            end
            default: begin
                w_mac_a = '0;
            end
        endcase
    end

    mm3_mac u_mac (
        .i_a (w_mac_a),
        .i_b (w_mac_b),
        .i_c (w_mac_c),
        .o_p (w_mac_p)
    );

    assign w_stat.in_valid   = s_axis_tvalid;
    assign w_stat.in_last    = s_axis_tlast;
    assign w_stat.in_empty   = (w_cnt == 3'd0);
    assign w_stat.full_block = !r_tail;
    assign w_stat.is_last    = r_last;
    assign w_stat.out_free   = !r_out_valid || m_axis_tready;

    mm3_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    // seed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_wdata;
        end
    end

    // key tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_key <= 1'b0;
        end else if (w_ctrl.emit) begin
            r_in_key <= 1'b0;
        end else if (w_accept) begin
            r_in_key <= 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_word <= s_axis_tdata & w_mask;
            r_last <= s_axis_tlast;
            r_tail <= s_axis_tlast && (w_cnt != 3'd0) && (w_cnt != MAX_BYTES);
            r_len  <= w_len_base + w_len_add;
            r_hash <= r_in_key ? r_hash : r_seed;
        end else begin
            unique case (w_ctrl.op)
                OP_MIX1, OP_MIX2: begin
                    r_k <= w_mac_p;
                end
                OP_ROUND, OP_FIN1, OP_FIN2: begin
                    r_hash <= w_mac_p;
                end
                OP_NONE: begin
                    r_k <= r_k;
                end
                default: begin
                    r_k <= r_k;
                end
            endcase
        end
    end

    // output stage: last shift-xor of the finalizer lands here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.emit) begin
            r_out_data <= r_hash ^ (r_hash >> 16);
        end
    end

    assign s_axis_tready = w_ctrl.ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

/* verif/murmur3_hash_32_test.sv */
// self-checking testbench for murmur3_hash_32: directed and random keys streamed in, hashes checked
// against an in-bench model of the 32-bit murmur3 hash; needs only the block's rtl
`timescale 1ns / 1ps

module murmur3_hash_32_test;

    // hash constants of the 32-bit murmur3 scheme
    localparam logic [31:0] K_MIX1      = 32'hcc9e2d51;
    localparam logic [31:0] K_MIX2      = 32'h1b873593;
    localparam logic [31:0] K_ROUND_ADD = 32'he6546b64;
    localparam logic [31:0] K_FIN1      = 32'h85ebca6b;
    localparam logic [31:0] K_FIN2      = 32'hc2b2ae35;
    localparam logic [31:0] SEED_AT_RST = 32'hb6871303;

    localparam int RST_CYCLES    = 11;
    localparam int SETTLE_CYCLES = 12;
    localparam int LIMIT_CYCLES  = 400000;  // far above the slowest passing run
    localparam int REPORT_MAX    = 10;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        last;
    } t_key_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // [31:0] data_word
    logic [2:0]  s_axis_tuser = '0;    // [2:0] byte_count
    logic        s_axis_tlast = 1'b0;  // is_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [31:0] hash_value

    murmur3_hash_32 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // beats waiting to be driven, hashes waiting to come out
    t_key_beat   beat_queue[$];
    logic [31:0] hash_due[$];
    int          beats_queued = 0;

    // model state: seed register plus per-key running state
    logic [31:0] seed_model = SEED_AT_RST;
    logic [31:0] run_hash = '0;
    logic [31:0] key_len = '0;
    logic        in_key = 1'b0;

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          rx_hold_len = 0;
    logic        rx_hold_req = 1'b0;   // toggled to start a long receiver stall
    logic        rx_hold_seen = 1'b0;
    int          rx_hold_left = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int r);
        return (v << r) | (v >> (32 - r));
    endfunction

    function automatic logic [31:0] scramble_word(input logic [31:0] k);
        logic [31:0] t;
        t = k * K_MIX1;
        t = rotl32(t, 15);
        return t * K_MIX2;
    endfunction

    // one full 4-byte block folded into the running hash
    function automatic logic [31:0] body_mix(input logic [31:0] h, input logic [31:0] k);
        logic [31:0] t;
        t = rotl32(h ^ scramble_word(k), 13);
        return t * 32'd5 + K_ROUND_ADD;
    endfunction

    // fmix32 avalanche
    function automatic logic [31:0] finalize(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * K_FIN1;
        t = t ^ (t >> 13);
        t = t * K_FIN2;
        return t ^ (t >> 16);
    endfunction

    // advance the model by one accepted key beat; a last beat yields a hash
    function automatic void absorb_beat(input logic [31:0] word, input logic [2:0] nbytes,
                                        input logic last);
        logic [31:0] h;
        logic [2:0]  n;
        logic [31:0] mask;
        if (!in_key) begin
            run_hash = seed_model;
            key_len  = '0;
            in_key   = 1'b1;
        end
        if (!last) begin
            // byte count is ignored on body beats
            run_hash = body_mix(run_hash, word);
            key_len  = key_len + 32'd4;
        end else begin
            // oversized byte counts saturate at four
            n = (nbytes > 3'd4) ? 3'd4 : nbytes;
            h = run_hash;
            if (n == 3'd4) begin
                h = body_mix(h, word);
            end else if (n != 3'd0) begin
                // bytes above the valid count are dropped
                mask = (32'h1 << (8 * n)) - 32'h1;
                h = h ^ scramble_word(word & mask);
            end
            key_len = key_len + {29'd0, n};
            hash_due.push_back(finalize(h ^ key_len));
            run_hash = '0;
            key_len  = '0;
            in_key   = 1'b0;
        end
    endfunction

    // timeout guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // driver: key beats from beat_queue, random gaps, model updated on each accepted beat
    always @(posedge i_clk) begin
        t_key_beat nb;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                absorb_beat(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            // slot is free when nothing is offered or the offered beat just went in
            if (!s_axis_tvalid || s_axis_tready) begin
                if (beat_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nb = beat_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nb.word;
                    s_axis_tuser  <= nb.nbytes;
                    s_axis_tlast  <= nb.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each hash beat against the oldest prediction, drives tready
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (hash_due.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected hash beat %08h at cycle %0d",
                                 m_axis_tdata, cycle_count);
                end else begin
                    want = hash_due.pop_front();
                    if (m_axis_tdata !== want) begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= REPORT_MAX)
                            $display("hash mismatch at cycle %0d: expected %08h, got %08h",
                                     cycle_count, want, m_axis_tdata);
                    end
                end
            end
            // a new stall request loads the hold-off counter
            if (rx_hold_req != rx_hold_seen) begin
                rx_hold_seen = rx_hold_req;
                rx_hold_left = rx_hold_len;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left = rx_hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic push_beat(input logic [31:0] word, input logic [2:0] nbytes,
                             input logic last);
        t_key_beat b;
        b.word   = word;
        b.nbytes = nbytes;
        b.last   = last;
        beat_queue.push_back(b);
        beats_queued = beats_queued + 1;
    endtask

    // mostly short keys, now and then a long one
    task automatic push_random_key();
        int nbody;
        nbody = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(5);
        repeat (nbody) push_beat($urandom, 3'($urandom_range(7)), 1'b0);
        push_beat($urandom, 3'($urandom_range(7)), 1'b1);
    endtask

    task automatic push_random_keys(input int nbeats);
        int start;
        start = beats_queued;
        while (beats_queued - start < nbeats)
            push_random_key();
    endtask

    // hold the sender until every hash is back and the block has gone quiet
    task automatic settle();
        do @(negedge i_clk);
        while (beat_queue.size() != 0 || s_axis_tvalid || hash_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        seed_model  = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed keys under the reset seed, sender rarely idle, receiver mostly stalled
        tx_idle_pct = 9;
        rx_idle_pct = 85;
        push_beat(32'hffffffff, 3'd0, 1'b1);       // empty key, data bits ignored
        push_beat(32'hffffffff, 3'd1, 1'b1);
        push_beat(32'hffffffff, 3'd2, 1'b1);
        push_beat(32'hffffffff, 3'd3, 1'b1);
        push_beat(32'hffffffff, 3'd4, 1'b1);       // full block then empty tail
        push_beat(32'h12345678, 3'd5, 1'b1);       // oversized counts act as four
        push_beat(32'h00000000, 3'd7, 1'b1);
        push_beat(32'hffffffff, 3'd7, 1'b0);       // count on a body beat is ignored
        push_beat(32'h00000000, 3'd3, 1'b1);
        settle();

        // seed extremes
        write_seed(32'h00000000);
        push_beat(32'h00000000, 3'd0, 1'b0);
        push_beat(32'hffffffff, 3'd2, 1'b0);
        push_beat(32'ha5a5a5a5, 3'd4, 1'b1);
        settle();
        write_seed(32'hffffffff);
        push_beat(32'h00000080, 3'd1, 1'b1);

        // seed changed in the middle of a key only applies to the next key
        push_beat(32'hdeadbeef, 3'd6, 1'b0);
        settle();
        write_seed(32'h5a5a5a5a);
        push_beat(32'hc0ffee11, 3'd2, 1'b1);
        push_beat(32'h00000000, 3'd0, 1'b1);
        settle();

        // random phase, slow receiver
        write_seed($urandom);
        push_random_keys(500);
        settle();

        // random phase, slow sender
        tx_idle_pct = 85;
        rx_idle_pct = 9;
        write_seed($urandom);
        push_random_keys(500);
        settle();

        // full rate; a long receiver hold-off first so the block backs up its input
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_seed(SEED_AT_RST);
        @(posedge i_clk);
        rx_hold_len <= 400;
        rx_hold_req <= ~rx_hold_req;
        push_random_keys(60);
        settle();
        write_seed($urandom);
        push_random_keys(480);
        settle();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && hash_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
